/* design/prd_pkg.sv */
`default_nettype none
package prd_pkg;

  localparam int MAX_IMAGE_SIDE = 4096;
  localparam int SIDE_W = 13;
  localparam int PIX_W  = 12;
  localparam int COMP_W = 21;
  localparam int VEC_W  = 63;
  localparam int OUT_W  = 16;
  localparam int OFF_W  = 14;
  localparam int PROD_W = 35;
  localparam int MAG_W  = 37;
  localparam int NGRP   = (MAG_W + 7) / 8;
  localparam int POS_W  = 6;
  localparam int A_W    = 16;
  localparam int SQ_W   = 32;
  localparam int SUM_W  = 34;
  localparam int LIM_W  = 64;
  localparam int ACC_W  = 68;
  localparam int Q_W    = 15;
  localparam int NSTEP  = 15;
  localparam int BIT_W  = 4;
  localparam int IDX_W  = 3;

  localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [IDX_W-1:0] REG_LOOK_VECTOR  = 3'd2;
  localparam logic [IDX_W-1:0] REG_RIGHT_STEP   = 3'd3;
  localparam logic [IDX_W-1:0] REG_UP_STEP      = 3'd4;

  localparam logic [Q_W-1:0] ONE_Q14 = 15'd16384;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_y;
    logic [PIX_W-1:0] pixel_x;
  } prd_in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] dir_z;
    logic signed [OUT_W-1:0] dir_y;
    logic signed [OUT_W-1:0] dir_x;
  } prd_out_t;

  typedef struct packed {
    logic [SIDE_W-1:0] image_width;
    logic [SIDE_W-1:0] image_height;
    logic [VEC_W-1:0]  look_vector;
    logic [VEC_W-1:0]  right_step;
    logic [VEC_W-1:0]  up_step;
  } prd_cfg_t;

  typedef struct packed {
    logic [2:0][MAG_W-1:0] mag;
    logic [2:0]            neg;
  } prd_mag_t;

  typedef struct packed {
    logic [2:0][Q_W-1:0]   q;
    logic [2:0][ACC_W-1:0] x;
    logic [2:0][ACC_W-1:0] y;
    logic [SUM_W-1:0]      s;
    logic [2:0][LIM_W-1:0] lim;
    logic [2:0]            neg;
    logic                  zero;
  } prd_iter_t;

  function automatic logic signed [COMP_W-1:0] comp_of(input logic [VEC_W-1:0] vec,
                                                       input int idx);
    comp_of = $signed(vec[idx*COMP_W +: COMP_W]);
  endfunction

endpackage
`default_nettype wire

/* design/pinhole_ray_direction.sv */
// channel   direction  handshake            payload
// in        input      in_valid / in_stall  in_data   (pixel_x, pixel_y)
// out       output     out_valid/ out_stall out_data  (dir_x, dir_y, dir_z)
// cfg       input      cfg_valid/ cfg_ready cfg_index, cfg_data
//
// one pixel per cycle while the output is not stalled
// the pipe ends in the 15 stages of the bitwise unit-magnitude search
// a stalled output holds the pipe; empty stages still fill while stalled
// rst is synchronous; it clears the stage valid bits and loads register defaults
`default_nettype none
module pinhole_ray_direction import prd_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire prd_in_t          in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output prd_out_t              out_data,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [IDX_W-1:0] cfg_index,
  input  wire logic [VEC_W-1:0] cfg_data
);

  prd_cfg_t cfg;

  logic     front_valid;
  logic     front_stall;
  prd_mag_t front_data;

  logic      st_valid [NSTEP+1];
  logic      st_stall [NSTEP+1];
  prd_iter_t st_data  [NSTEP+1];
  prd_iter_t last;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width  <= SIDE_W'(640);
      cfg.image_height <= SIDE_W'(480);
      cfg.look_vector  <= '0;
      cfg.right_step   <= '0;
      cfg.up_step      <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  cfg.image_width  <= cfg_data[SIDE_W-1:0];
        REG_IMAGE_HEIGHT: cfg.image_height <= cfg_data[SIDE_W-1:0];
        REG_LOOK_VECTOR:  cfg.look_vector  <= cfg_data;
        REG_RIGHT_STEP:   cfg.right_step   <= cfg_data;
        REG_UP_STEP:      cfg.up_step      <= cfg_data;
        default: ;
      endcase
    end
  end

  prd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .valid_in  (in_valid),
    .data_in   (in_data),
    .stall     (in_stall),
    .valid_out (front_valid),
    .data_out  (front_data),
    .hold      (front_stall)
  );

  prd_norm u_norm (
    .clk       (clk),
    .rst       (rst),
    .valid_in  (front_valid),
    .data_in   (front_data),
    .stall     (front_stall),
    .valid_out (st_valid[0]),
    .data_out  (st_data[0]),
    .hold      (st_stall[0])
  );

  for (genvar k = 0; k < NSTEP; k++) begin : g_step
    prd_step u_step (
      .clk       (clk),
      .rst       (rst),
      .bit_idx   (BIT_W'(NSTEP-1-k)),
      .valid_in  (st_valid[k]),
      .data_in   (st_data[k]),
      .stall     (st_stall[k]),
      .valid_out (st_valid[k+1]),
      .data_out  (st_data[k+1]),
      .hold      (st_stall[k+1])
    );
  end

  assign st_stall[NSTEP] = out_stall;
  assign last            = st_data[NSTEP];
  assign out_valid       = st_valid[NSTEP];

  always_comb begin
    if (last.zero) begin
      out_data = '0;
    end else begin
      out_data.dir_x = last.neg[0] ? -$signed(OUT_W'(last.q[0])) : $signed(OUT_W'(last.q[0]));
      out_data.dir_y = last.neg[1] ? -$signed(OUT_W'(last.q[1])) : $signed(OUT_W'(last.q[1]));
      out_data.dir_z = last.neg[2] ? -$signed(OUT_W'(last.q[2])) : $signed(OUT_W'(last.q[2]));
    end
  end

  a_full_only: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while pipe has room");

  a_q_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last.q[0] <= ONE_Q14 && last.q[1] <= ONE_Q14 && last.q[2] <= ONE_Q14))
    else $error("unit magnitude above one");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule
`default_nettype wire

/* design/prd_front.sv */
`default_nettype none
module prd_front import prd_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire prd_cfg_t cfg,
  input  wire logic     valid_in,
  input  wire prd_in_t  data_in,
  output logic          stall,
  output logic          valid_out,
  output prd_mag_t      data_out,
  input  wire logic     hold
);

  logic [3:0] v;
  logic [3:0] en;

  logic [SIDE_W-1:0] w_cl;
  logic [SIDE_W-1:0] h_cl;

  logic signed [OFF_W-1:0]  hx;
  logic signed [OFF_W-1:0]  vy;
  logic signed [PROD_W-1:0] pr_h [3];
  logic signed [PROD_W-1:0] pr_v [3];
  logic [MAG_W-1:0]         d [3];

  always_comb begin
    en[3] = !v[3] || !hold;
    for (int j = 2; j >= 0; j--) en[j] = !v[j] || en[j+1];
  end

  assign stall     = !en[0];
  assign valid_out = v[3];

  always_comb begin
    if (cfg.image_width == '0) w_cl = SIDE_W'(1);
    else if (cfg.image_width > SIDE_W'(MAX_IMAGE_SIDE)) w_cl = SIDE_W'(MAX_IMAGE_SIDE);
    else w_cl = cfg.image_width;
    if (cfg.image_height == '0) h_cl = SIDE_W'(1);
    else if (cfg.image_height > SIDE_W'(MAX_IMAGE_SIDE)) h_cl = SIDE_W'(MAX_IMAGE_SIDE);
    else h_cl = cfg.image_height;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= valid_in;
      if (en[1]) v[1] <= v[0];
      if (en[2]) v[2] <= v[1];
      if (en[3]) v[3] <= v[2];
    end
  end

  // half-pixel offsets
  always_ff @(posedge clk) begin
    if (en[0]) begin
      hx <= $signed({1'b0, data_in.pixel_x, 1'b0}) - $signed({1'b0, w_cl});
      vy <= $signed({1'b0, h_cl}) - $signed({1'b0, data_in.pixel_y, 1'b0});
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int i = 0; i < 3; i++) begin
        pr_h[i] <= hx * comp_of(cfg.right_step, i);
        pr_v[i] <= vy * comp_of(cfg.up_step, i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int i = 0; i < 3; i++) begin
        d[i] <= MAG_W'(comp_of(cfg.look_vector, i)) + MAG_W'(comp_of(cfg.look_vector, i))
              + MAG_W'(pr_h[i]) + MAG_W'(pr_v[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int i = 0; i < 3; i++) begin
        data_out.neg[i] <= d[i][MAG_W-1];
        data_out.mag[i] <= d[i][MAG_W-1] ? (MAG_W'(0) - d[i]) : d[i];
      end
    end
  end

endmodule
`default_nettype wire

/* design/prd_norm.sv */
`default_nettype none
module prd_norm import prd_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     valid_in,
  input  wire prd_mag_t data_in,
  output logic          stall,
  output logic          valid_out,
  output prd_iter_t     data_out,
  input  wire logic     hold
);

  logic [3:0] v;
  logic [3:0] en;

  logic [NGRP*8-1:0] m_pad;
  logic [NGRP-1:0]   gnz_next;
  logic [2:0]        gpos_next [NGRP];

  prd_mag_t        r0;
  logic            zero0;
  logic [NGRP-1:0] gnz;
  logic [2:0]      gpos [NGRP];

  logic [POS_W-1:0] p;
  logic [2:0]       neg1;
  logic             zero1;
  logic [A_W-1:0]   a [3];

  logic [2:0]      neg2;
  logic            zero2;
  logic [SQ_W-1:0] sq [3];

  logic [SUM_W-1:0] s_sum;

  always_comb begin
    en[3] = !v[3] || !hold;
    for (int j = 2; j >= 0; j--) en[j] = !v[j] || en[j+1];
  end

  assign stall     = !en[0];
  assign valid_out = v[3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= valid_in;
      if (en[1]) v[1] <= v[0];
      if (en[2]) v[2] <= v[1];
      if (en[3]) v[3] <= v[2];
    end
  end

  // leading one per byte group
  always_comb begin
    m_pad = (NGRP*8)'(data_in.mag[0] | data_in.mag[1] | data_in.mag[2]);
    for (int g = 0; g < NGRP; g++) begin
      gnz_next[g]  = 1'b0;
      gpos_next[g] = 3'd0;
      for (int k = 0; k < 8; k++) begin
        if (m_pad[8*g+k]) begin
          gnz_next[g]  = 1'b1;
          gpos_next[g] = 3'(k);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      r0    <= data_in;
      zero0 <= !(|m_pad);
      gnz   <= gnz_next;
      for (int g = 0; g < NGRP; g++) gpos[g] <= gpos_next[g];
    end
  end

  always_comb begin
    p = '0;
    for (int g = 0; g < NGRP; g++) begin
      if (gnz[g]) p = POS_W'(8*g) + POS_W'(gpos[g]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      neg1  <= r0.neg;
      zero1 <= zero0;
      for (int i = 0; i < 3; i++) begin
        if (p >= POS_W'(A_W-1)) a[i] <= A_W'(r0.mag[i] >> (p - POS_W'(A_W-1)));
        else a[i] <= A_W'(r0.mag[i] << (POS_W'(A_W-1) - p));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      neg2  <= neg1;
      zero2 <= zero1;
      for (int i = 0; i < 3; i++) sq[i] <= a[i] * a[i];
    end
  end

  assign s_sum = SUM_W'(sq[0]) + SUM_W'(sq[1]) + SUM_W'(sq[2]);

  // start with q = 0, odd term -1
  always_ff @(posedge clk) begin
    if (en[3]) begin
      data_out.s    <= s_sum;
      data_out.neg  <= neg2;
      data_out.zero <= zero2;
      for (int i = 0; i < 3; i++) begin
        data_out.q[i]   <= '0;
        data_out.x[i]   <= ACC_W'(s_sum);
        data_out.y[i]   <= ACC_W'(0) - ACC_W'(s_sum);
        data_out.lim[i] <= LIM_W'({sq[i], 30'b0});
      end
    end
  end

endmodule
`default_nettype wire

/* design/prd_step.sv */
`default_nettype none
module prd_step import prd_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [BIT_W-1:0] bit_idx,
  input  wire logic             valid_in,
  input  wire prd_iter_t        data_in,
  output logic                  stall,
  output logic                  valid_out,
  output prd_iter_t             data_out,
  input  wire logic             hold
);

  logic en;
  logic [ACC_W-1:0] sx;
  logic [ACC_W-1:0] xc [3];
  logic [ACC_W-1:0] yc [3];
  logic [2:0]       take;

  assign en        = !valid_out || !hold;
  assign stall     = !en;
  assign sx        = ACC_W'(data_in.s);

  // (o + 2d)^2 s from o^2 s and o s with shifts only
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      xc[i] = data_in.x[i] + (data_in.y[i] << ({1'b0, bit_idx} + 5'd2))
            + (sx << ({bit_idx, 1'b0} + 5'd2));
      yc[i] = data_in.y[i] + (sx << ({1'b0, bit_idx} + 5'd1));
      take[i] = !data_in.q[i][Q_W-1]
             && ($signed(xc[i]) <= $signed(ACC_W'(data_in.lim[i])));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) valid_out <= 1'b0;
    else if (en) valid_out <= valid_in;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_out.s    <= data_in.s;
      data_out.lim  <= data_in.lim;
      data_out.neg  <= data_in.neg;
      data_out.zero <= data_in.zero;
      for (int i = 0; i < 3; i++) begin
        if (take[i]) begin
          data_out.q[i] <= data_in.q[i] | (Q_W'(1) << bit_idx);
          data_out.x[i] <= xc[i];
          data_out.y[i] <= yc[i];
        end else begin
          data_out.q[i] <= data_in.q[i];
          data_out.x[i] <= data_in.x[i];
          data_out.y[i] <= data_in.y[i];
        end
      end
    end
  end

endmodule
`default_nettype wire

/* tb/tb_pinhole_ray_direction.sv */
`timescale 1ns / 100ps
`default_nettype none

class ray_dir_scoreboard;
  logic [12:0] width_r, height_r;
  logic [62:0] look_r, right_r, up_r;
  prd_pkg::prd_out_t pending_dirs[$];
  int errors;

  function new();
    width_r = 13'd640;
    height_r = 13'd480;
    look_r = '0;
    right_r = '0;
    up_r = '0;
    errors = 0;
  endfunction

  function void write_reg(logic [2:0] idx, logic [62:0] val);
    case (idx)
      prd_pkg::REG_IMAGE_WIDTH: width_r = val[12:0];
      prd_pkg::REG_IMAGE_HEIGHT: height_r = val[12:0];
      prd_pkg::REG_LOOK_VECTOR: look_r = val;
      prd_pkg::REG_RIGHT_STEP: right_r = val;
      prd_pkg::REG_UP_STEP: up_r = val;
      default: ;
    endcase
  endfunction

  function longint side_of(logic [12:0] v);
    if (v == 0) return 1;
    if (v > prd_pkg::MAX_IMAGE_SIDE) return prd_pkg::MAX_IMAGE_SIDE;
    return longint'(v);
  endfunction

  function longint comp(logic [62:0] v, int i);
    logic signed [20:0] c;
    c = v[i*21 +: 21];
    return longint'(c);
  endfunction

  function longint unsigned unit_q(longint unsigned a, longint unsigned s);
    longint unsigned q, t, odd, lim;
    q = 0;
    lim = (a * a) << 30;
    for (int b = 14; b >= 0; b--) begin
      t = q | (64'd1 << b);
      if (t <= 16384) begin
        odd = 2 * t - 1;
        if (odd * odd * s <= lim) q = t;
      end
    end
    return q;
  endfunction

  function void note_pixel(prd_pkg::prd_in_t px);
    longint hx, vy, d;
    longint unsigned mag[3], m, s, q;
    logic neg[3];
    logic [15:0] r[3];
    prd_pkg::prd_out_t dir;
    hx = 2 * longint'(px.pixel_x) - side_of(width_r);
    vy = side_of(height_r) - 2 * longint'(px.pixel_y);
    m = 0;
    for (int i = 0; i < 3; i++) begin
      d = 2 * comp(look_r, i) + hx * comp(right_r, i) + vy * comp(up_r, i);
      neg[i] = d < 0;
      mag[i] = neg[i] ? longint'(-d) : longint'(d);
      if (mag[i] > m) m = mag[i];
    end
    if (m == 0) begin
      r[0] = 0; r[1] = 0; r[2] = 0;
    end else begin
      while (m >= 65536) begin
        m >>= 1;
        for (int i = 0; i < 3; i++) mag[i] >>= 1;
      end
      while (m < 32768) begin
        m <<= 1;
        for (int i = 0; i < 3; i++) mag[i] <<= 1;
      end
      s = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
      for (int i = 0; i < 3; i++) begin
        q = unit_q(mag[i], s);
        r[i] = neg[i] ? 16'(-q) : 16'(q);
      end
    end
    dir.dir_x = r[0];
    dir.dir_y = r[1];
    dir.dir_z = r[2];
    pending_dirs.push_back(dir);
  endfunction

  function void check_dir(prd_pkg::prd_out_t got);
    prd_pkg::prd_out_t exp_d;
    if (pending_dirs.size() == 0) begin
      $display("%0t unexpected ray: expected none actual %h", $time, got);
      errors++;
      return;
    end
    exp_d = pending_dirs.pop_front();
    if (got.dir_x !== exp_d.dir_x) begin
      $display("%0t dir_x mismatch: expected %0d actual %0d", $time, exp_d.dir_x, got.dir_x);
      errors++;
    end
    if (got.dir_y !== exp_d.dir_y) begin
      $display("%0t dir_y mismatch: expected %0d actual %0d", $time, exp_d.dir_y, got.dir_y);
      errors++;
    end
    if (got.dir_z !== exp_d.dir_z) begin
      $display("%0t dir_z mismatch: expected %0d actual %0d", $time, exp_d.dir_z, got.dir_z);
      errors++;
    end
  endfunction
endclass

module tb_pinhole_ray_direction;
  import prd_pkg::*;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  prd_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 0;
  prd_out_t out_data;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [VEC_W-1:0] cfg_data = '0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  ray_dir_scoreboard sb = new();

  pinhole_ray_direction DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_pixel(in_data);
      if (out_valid && !out_stall) sb.check_dir(out_data);
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // valid stays up after the transfer until the next call or an idle task drops it
  task automatic send_pixel(logic [11:0] px, logic [11:0] py);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_data.pixel_x <= px;
    in_data.pixel_y <= py;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending_dirs.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  // registers change only with the pipe empty
  task automatic write_reg(logic [IDX_W-1:0] idx, logic [VEC_W-1:0] val);
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending_dirs.size() != 0) @(posedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, val);
    cfg_valid <= 0;
  endtask

  function automatic logic [20:0] rand_comp(int range_bits);
    logic [20:0] c;
    c = 21'($urandom);
    if (range_bits < 21) c = 21'($signed(c << (21 - range_bits)) >>> (21 - range_bits));
    return c;
  endfunction

  function automatic logic [62:0] rand_vec(int range_bits);
    return {rand_comp(range_bits), rand_comp(range_bits), rand_comp(range_bits)};
  endfunction

  task automatic set_camera(logic [12:0] w, logic [12:0] h, int lb, int sb_bits);
    write_reg(REG_IMAGE_WIDTH, 63'(w));
    write_reg(REG_IMAGE_HEIGHT, 63'(h));
    write_reg(REG_LOOK_VECTOR, rand_vec(lb));
    write_reg(REG_RIGHT_STEP, rand_vec(sb_bits));
    write_reg(REG_UP_STEP, rand_vec(sb_bits));
  endtask

  task automatic random_pixels(int n, int w, int h);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) send_pixel(12'($urandom), 12'($urandom));
      else send_pixel(12'($urandom_range(w)), 12'($urandom_range(h)));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // defaults: zero vectors
    send_pixel(0, 0);
    send_pixel(12'hfff, 12'hfff);

    // exact axes and corner cases
    write_reg(REG_LOOK_VECTOR, {21'd0, 21'd0, 21'h040000});
    write_reg(REG_RIGHT_STEP, '0);
    write_reg(REG_UP_STEP, '0);
    write_reg(3'd7, '1);
    send_pixel(320, 240);
    write_reg(REG_LOOK_VECTOR, {21'h100000, 21'h0fffff, 21'h100000});
    send_pixel(5, 5);
    write_reg(REG_LOOK_VECTOR, {21'd1, 21'd0, 21'h1fffff});
    send_pixel(5, 5);
    set_camera(13'd0, 13'd0, 21, 21);
    send_pixel(0, 0);
    send_pixel(12'hfff, 12'hfff);
    send_pixel(12'hfff, 0);
    send_pixel(0, 12'hfff);
    set_camera(13'h1fff, 13'd4097, 21, 21);
    send_pixel(0, 0);
    send_pixel(12'hfff, 12'hfff);
    send_pixel(2048, 2048);
    set_camera(13'd4096, 13'd4096, 21, 8);
    send_pixel(2048, 2048);
    send_pixel(0, 12'hfff);
    set_camera(13'd1, 13'd1, 3, 3);
    send_pixel(0, 0);
    send_pixel(1, 1);
    drain();

    for (int ph = 0; ph < 9; ph++) begin
      int w, h;
      case (ph % 3)
        0: begin send_idle_pct = 27; recv_idle_pct = 63; end
        1: begin send_idle_pct = 63; recv_idle_pct = 27; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      w = (ph < 3) ? 640 : (ph < 6) ? $urandom_range(1, 64) : 4096;
      h = (ph < 3) ? 480 : (ph < 6) ? $urandom_range(1, 64) : $urandom_range(1, 4096);
      set_camera(13'(w), 13'(h), 21, (ph % 2) ? 10 : 21);
      random_pixels(110, w, h);
      drain();
    end

    if (sb.errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end
endmodule

`default_nettype wire

/* pinhole_ray_direction.f */
design/prd_pkg.sv
design/prd_front.sv
design/prd_norm.sv
design/prd_step.sv
design/pinhole_ray_direction.sv
tb/tb_pinhole_ray_direction.sv
